// File: sv/esrp_pkg.sv
`timescale 1ns / 1ps

package esrp_pkg;

  // stack symbols
  localparam logic [3:0] SYM_BOT   = 4'd0;
  localparam logic [3:0] SYM_E     = 4'd1;
  localparam logic [3:0] SYM_T     = 4'd2;
  localparam logic [3:0] SYM_F     = 4'd3;
  localparam logic [3:0] SYM_ID    = 4'd4;
  localparam logic [3:0] SYM_PLUS  = 4'd5;
  localparam logic [3:0] SYM_TIMES = 4'd6;
  localparam logic [3:0] SYM_OPEN  = 4'd7;
  localparam logic [3:0] SYM_CLOSE = 4'd8;

  // input tokens
  localparam logic [2:0] TOK_CLOSE = 3'd4;
  localparam logic [2:0] TOK_TIMES = 3'd2;
  localparam logic [2:0] TOK_END   = 3'd5;

  // reported actions
  localparam logic [3:0] ACT_SHIFT    = 4'd0;
  localparam logic [3:0] ACT_E_PLUS_T = 4'd1;
  localparam logic [3:0] ACT_T_MUL_F  = 4'd2;
  localparam logic [3:0] ACT_PAREN    = 4'd3;
  localparam logic [3:0] ACT_ID_F     = 4'd4;
  localparam logic [3:0] ACT_F_T      = 4'd5;
  localparam logic [3:0] ACT_T_E      = 4'd6;
  localparam logic [3:0] ACT_ACCEPT   = 4'd7;
  localparam logic [3:0] ACT_REJECT   = 4'd8;
  localparam logic [3:0] ACT_OVERFLOW = 4'd9;

  // microcode operations
  localparam logic [1:0] OP_FIN   = 2'd0;
  localparam logic [1:0] OP_SHIFT = 2'd1;
  localparam logic [1:0] OP_RED   = 2'd2;
  localparam logic [1:0] OP_VERD  = 2'd3;

  // program addresses
  localparam logic [2:0] STEP_FIN   = 3'd0;
  localparam logic [2:0] STEP_SHIFT = 3'd1;
  localparam logic [2:0] STEP_RED0  = 3'd2;
  localparam logic [2:0] STEP_RED1  = 3'd3;
  localparam logic [2:0] STEP_RED2  = 3'd4;
  localparam logic [2:0] STEP_RED3  = 3'd5;
  localparam logic [2:0] STEP_VERD  = 3'd6;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] nxt;   // next step when the step completes or matches
    logic [2:0] alt;   // jump target when a reduction finds no match
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [2:0] addr);
    ucode_t uw;
    uw = '{op: OP_FIN, nxt: STEP_FIN, alt: STEP_FIN};
    unique case (addr)
      STEP_FIN:   uw = '{op: OP_FIN,   nxt: STEP_SHIFT, alt: STEP_FIN};
      STEP_SHIFT: uw = '{op: OP_SHIFT, nxt: STEP_RED0,  alt: STEP_RED0};
      STEP_RED0:  uw = '{op: OP_RED,   nxt: STEP_RED1,  alt: STEP_VERD};
      STEP_RED1:  uw = '{op: OP_RED,   nxt: STEP_RED2,  alt: STEP_VERD};
      STEP_RED2:  uw = '{op: OP_RED,   nxt: STEP_RED3,  alt: STEP_VERD};
      STEP_RED3:  uw = '{op: OP_RED,   nxt: STEP_VERD,  alt: STEP_VERD};
      STEP_VERD:  uw = '{op: OP_VERD,  nxt: STEP_FIN,   alt: STEP_FIN};
      default:    uw = '{op: OP_FIN,   nxt: STEP_FIN,   alt: STEP_FIN};
    endcase
    return uw;
  endfunction

endpackage

// File: sv/expression_shift_reduce_parser.sv
// Each word runs a seven-step microprogram: shift, up to four reductions, verdict, finish.
// One step per cycle unless an output stall holds the sequencer; the finish step takes the next word.
// Results leave through a one-deep pending register and then an output register;
// output stalls hold the sequencer.
// Reset (async, active low): stack holds only the bottom marker, nothing pending.
`timescale 1ns / 1ps

module expression_shift_reduce_parser #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] token_i,
  input  logic [2:0] lookahead_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] action_o,
  output logic [3:0] symbol_o,
  output logic [5:0] stack_level_o,
  output logic       run_end_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  // stack as a shift line: entry 0 is the top, unused entries hold the bottom code
  logic [3:0]    stk_q [STACK_DEPTH];
  logic [3:0]    stk_d [STACK_DEPTH];
  logic [CW-1:0] cnt_q, cnt_d;
  logic          fault_q, fault_d;
  logic [2:0]    step_q, step_d;
  logic [2:0]    tok_q;
  logic [2:0]    la_q;

  logic          pnd_v_q, pnd_v_d;
  logic [3:0]    pnd_act_q, pnd_sym_q;
  logic [5:0]    pnd_lvl_q;

  logic          out_v_q;
  logic [3:0]    out_act_q, out_sym_q;
  logic [5:0]    out_lvl_q;
  logic          out_end_q;

  esrp_pkg::ucode_t uw;
  logic          out_free, go, in_acc;
  logic          emit, out_load, out_end;
  logic [3:0]    emit_act;
  logic [CW+5:0] cnt_ext;

  // reduction decode
  logic          la_times, three, two, full;
  logic [3:0]    red_act, red_sym;
  logic          red_pop;

  assign uw       = esrp_pkg::ucode_rom(step_q);
  assign out_free = !out_v_q || out_ready_i;
  assign go       = !pnd_v_q || out_free;
  assign in_ready_o = (uw.op == esrp_pkg::OP_FIN) && go;
  assign in_acc   = in_valid_i && in_ready_o;

  assign la_times = (la_q == esrp_pkg::TOK_TIMES);
  assign three    = (cnt_q >= CW'(4));
  assign two      = (cnt_q >= CW'(2));
  assign full     = (cnt_q >= CW'(STACK_DEPTH));

  always_comb begin
    red_act = esrp_pkg::ACT_SHIFT;   // no match
    red_sym = stk_q[0];
    red_pop = 1'b0;
    if (three && !la_times && stk_q[0] == esrp_pkg::SYM_T &&
        stk_q[1] == esrp_pkg::SYM_PLUS && stk_q[2] == esrp_pkg::SYM_E) begin
      red_act = esrp_pkg::ACT_E_PLUS_T;
      red_sym = esrp_pkg::SYM_E;
      red_pop = 1'b1;
    end else if (three && !la_times && stk_q[0] == esrp_pkg::SYM_F &&
                 stk_q[1] == esrp_pkg::SYM_TIMES && stk_q[2] == esrp_pkg::SYM_T) begin
      red_act = esrp_pkg::ACT_T_MUL_F;
      red_sym = esrp_pkg::SYM_T;
      red_pop = 1'b1;
    end else if (three && stk_q[0] == esrp_pkg::SYM_CLOSE &&
                 stk_q[1] == esrp_pkg::SYM_E && stk_q[2] == esrp_pkg::SYM_OPEN) begin
      red_act = esrp_pkg::ACT_PAREN;
      red_sym = esrp_pkg::SYM_F;
      red_pop = 1'b1;
    end else if (two && stk_q[0] == esrp_pkg::SYM_ID) begin
      red_act = esrp_pkg::ACT_ID_F;
      red_sym = esrp_pkg::SYM_F;
    end else if (two && stk_q[0] == esrp_pkg::SYM_F) begin
      red_act = esrp_pkg::ACT_F_T;
      red_sym = esrp_pkg::SYM_T;
    end else if (two && !la_times && stk_q[0] == esrp_pkg::SYM_T) begin
      red_act = esrp_pkg::ACT_T_E;
      red_sym = esrp_pkg::SYM_E;
    end
  end

  // sequencer and datapath
  always_comb begin
    stk_d    = stk_q;
    cnt_d    = cnt_q;
    fault_d  = fault_q;
    step_d   = step_q;
    emit     = 1'b0;
    emit_act = esrp_pkg::ACT_SHIFT;
    unique case (uw.op)
      esrp_pkg::OP_FIN: begin
        if (in_acc) step_d = uw.nxt;
      end
      esrp_pkg::OP_SHIFT: begin
        if (go) begin
          step_d = uw.nxt;
          if (tok_q <= esrp_pkg::TOK_CLOSE) begin
            emit = 1'b1;
            if (full) begin
              fault_d  = 1'b1;
              emit_act = esrp_pkg::ACT_OVERFLOW;
            end else begin
              for (int i = 1; i < STACK_DEPTH; i++) stk_d[i] = stk_q[i-1];
              stk_d[0] = {1'b0, tok_q} + 4'd4;
              cnt_d    = cnt_q + CW'(1);
            end
          end else begin
            fault_d = 1'b1;
          end
        end
      end
      esrp_pkg::OP_RED: begin
        if (go) begin
          if (red_act != esrp_pkg::ACT_SHIFT) begin
            step_d   = uw.nxt;
            emit     = 1'b1;
            emit_act = red_act;
            if (red_pop) begin
              for (int i = 1; i < STACK_DEPTH; i++) begin
                if (i + 2 < STACK_DEPTH) stk_d[i] = stk_q[i+2];
                else stk_d[i] = esrp_pkg::SYM_BOT;
              end
              cnt_d = cnt_q - CW'(2);
            end
            stk_d[0] = red_sym;
          end else begin
            step_d = uw.alt;
          end
        end
      end
      esrp_pkg::OP_VERD: begin
        if (go) begin
          step_d = uw.nxt;
          if (la_q == esrp_pkg::TOK_END) begin
            emit = 1'b1;
            if (!fault_q && cnt_q == CW'(2) && stk_q[0] == esrp_pkg::SYM_E)
              emit_act = esrp_pkg::ACT_ACCEPT;
            else
              emit_act = esrp_pkg::ACT_REJECT;
            for (int i = 0; i < STACK_DEPTH; i++) stk_d[i] = esrp_pkg::SYM_BOT;
            cnt_d   = CW'(1);
            fault_d = 1'b0;
          end
        end
      end
      default: step_d = esrp_pkg::STEP_FIN;
    endcase
  end

  // a result waits in the pending register until it is known whether another follows
  always_comb begin
    out_load = 1'b0;
    out_end  = 1'b0;
    pnd_v_d  = pnd_v_q;
    if (emit) begin
      out_load = pnd_v_q;
      pnd_v_d  = 1'b1;
    end else if (uw.op == esrp_pkg::OP_FIN && pnd_v_q && out_free) begin
      out_load = 1'b1;
      out_end  = 1'b1;
      pnd_v_d  = 1'b0;
    end
  end

  assign cnt_ext = {6'b0, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= esrp_pkg::SYM_BOT;
      cnt_q   <= CW'(1);
      fault_q <= 1'b0;
      step_q  <= esrp_pkg::STEP_FIN;
      pnd_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      stk_q   <= stk_d;
      cnt_q   <= cnt_d;
      fault_q <= fault_d;
      step_q  <= step_d;
      pnd_v_q <= pnd_v_d;
      if (out_load) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tok_q <= token_i;
      la_q  <= lookahead_i;
    end
    if (emit) begin
      pnd_act_q <= emit_act;
      pnd_sym_q <= stk_d[0];
      pnd_lvl_q <= cnt_ext[5:0];
    end
    if (out_load) begin
      out_act_q <= pnd_act_q;
      out_sym_q <= pnd_sym_q;
      out_lvl_q <= pnd_lvl_q;
      out_end_q <= out_end;
    end
  end

  assign out_valid_o   = out_v_q;
  assign action_o      = out_act_q;
  assign symbol_o      = out_sym_q;
  assign stack_level_o = out_lvl_q;
  assign run_end_o     = out_end_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CW'(STACK_DEPTH)))
    else $error("stack count out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (step_q == esrp_pkg::STEP_SHIFT))
    else $error("accepted word did not start the program");

  a_verdict_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_act_q == esrp_pkg::ACT_ACCEPT || out_act_q == esrp_pkg::ACT_REJECT))
    |-> (out_end_q && out_sym_q == esrp_pkg::SYM_BOT && out_lvl_q == 6'd1))
    else $error("verdict word malformed");

  a_bottom_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CW'(1)) |-> (stk_q[0] == esrp_pkg::SYM_BOT))
    else $error("empty stack with a symbol on top");

endmodule
